/* hdl/lvrk_pkg.sv */
// Shared types and constants for the RK4 step pipeline.
package lvrk_pkg;

	localparam int NUM_REGS = 7;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_ALPHA  = 3'd0,
		REG_BETA   = 3'd1,
		REG_DELTA  = 3'd2,
		REG_GAMMA  = 3'd3,
		REG_KAPPA  = 3'd4,
		REG_LAMBDA = 3'd5,
		REG_DT     = 3'd6
	} reg_idx_t;

endpackage

/* hdl/lvrk_mul.sv */
// Registered saturating fixed-point multiplier: full product, floor shift, clamp to the word.
module lvrk_mul #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 20
) (
	input  logic                         clk,
	input  logic signed [WORD_WIDTH-1:0] a,
	input  logic signed [WORD_WIDTH-1:0] b,
	output logic signed [WORD_WIDTH-1:0] p_q,
	output logic                         ov_q
);
	localparam int PW = 2 * WORD_WIDTH;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] shf;
	logic signed [PW-1:0] wmax;
	logic signed [PW-1:0] wmin;

	// Arithmetic shift of the exact product is the floor of the scaled value.
	assign prod = PW'(a) * PW'(b);
	assign shf  = prod >>> FRAC_BITS;
	assign wmax = PW'({1'b0, {(WORD_WIDTH-1){1'b1}}});
	assign wmin = ~wmax;

	always_ff @(posedge clk) begin
		if (shf > wmax) begin
			p_q  <= wmax[WORD_WIDTH-1:0];
			ov_q <= 1'b1;
		end else if (shf < wmin) begin
			p_q  <= wmin[WORD_WIDTH-1:0];
			ov_q <= 1'b1;
		end else begin
			p_q  <= shf[WORD_WIDTH-1:0];
			ov_q <= 1'b0;
		end
	end
endmodule

/* hdl/lvrk_add.sv */
// Registered saturating adder or subtractor on word-wide signed values.
module lvrk_add #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         sub,
	input  logic signed [WORD_WIDTH-1:0] a,
	input  logic signed [WORD_WIDTH-1:0] b,
	output logic signed [WORD_WIDTH-1:0] s_q,
	output logic                         ov_q
);
	logic signed [WORD_WIDTH:0] sum;

	assign sum = sub ? ((WORD_WIDTH+1)'(a) - (WORD_WIDTH+1)'(b))
	                 : ((WORD_WIDTH+1)'(a) + (WORD_WIDTH+1)'(b));

	always_ff @(posedge clk) begin
		if (sum[WORD_WIDTH] != sum[WORD_WIDTH-1]) begin
			s_q  <= sum[WORD_WIDTH] ? {1'b1, {(WORD_WIDTH-1){1'b0}}}
			                        : {1'b0, {(WORD_WIDTH-1){1'b1}}};
			ov_q <= 1'b1;
		end else begin
			s_q  <= sum[WORD_WIDTH-1:0];
			ov_q <= 1'b0;
		end
	end
endmodule

/* hdl/lvrk_stage.sv */
// One RK4 stage: from a probe point it forms dt*f for both species, five register stages deep.
module lvrk_stage #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 20
) (
	input  logic                         clk,
	input  logic signed [WORD_WIDTH-1:0] alpha,
	input  logic signed [WORD_WIDTH-1:0] beta,
	input  logic signed [WORD_WIDTH-1:0] delta,
	input  logic signed [WORD_WIDTH-1:0] gamma,
	input  logic signed [WORD_WIDTH-1:0] kappa,
	input  logic signed [WORD_WIDTH-1:0] lambda,
	input  logic signed [WORD_WIDTH-1:0] dt,
	input  logic signed [WORD_WIDTH-1:0] x,
	input  logic signed [WORD_WIDTH-1:0] y,
	output logic signed [WORD_WIDTH-1:0] kx,
	output logic signed [WORD_WIDTH-1:0] ky,
	output logic                         ov
);
	localparam int W = WORD_WIDTH;

	// Stage 1: first products.
	logic signed [W-1:0] ax_s1, bx_s1, kxx_s1, dx_s1, gy_s1, ly_s1, x_s1, y_s1;
	logic o_ax, o_bx, o_kx, o_dx, o_gy, o_ly;
	lvrk_mul #(W, FRAC_BITS) u_ax (clk, alpha,  x, ax_s1,  o_ax);
	lvrk_mul #(W, FRAC_BITS) u_bx (clk, beta,   x, bx_s1,  o_bx);
	lvrk_mul #(W, FRAC_BITS) u_kx (clk, kappa,  x, kxx_s1, o_kx);
	lvrk_mul #(W, FRAC_BITS) u_dx (clk, delta,  x, dx_s1,  o_dx);
	lvrk_mul #(W, FRAC_BITS) u_gy (clk, gamma,  y, gy_s1,  o_gy);
	lvrk_mul #(W, FRAC_BITS) u_ly (clk, lambda, y, ly_s1,  o_ly);
	logic ov_s1;
	always_ff @(posedge clk) begin
		x_s1 <= x;
		y_s1 <= y;
	end
	assign ov_s1 = o_ax | o_bx | o_kx | o_dx | o_gy | o_ly;

	// Stage 2: second products.
	logic signed [W-1:0] bxy_s2, kxx2_s2, dxy_s2, lyy_s2, ax_s2, gy_s2;
	logic o_bxy, o_kxx, o_dxy, o_lyy, ov_s2;
	lvrk_mul #(W, FRAC_BITS) u_bxy (clk, bx_s1,  y_s1, bxy_s2,  o_bxy);
	lvrk_mul #(W, FRAC_BITS) u_kxx (clk, kxx_s1, x_s1, kxx2_s2, o_kxx);
	lvrk_mul #(W, FRAC_BITS) u_dxy (clk, dx_s1,  y_s1, dxy_s2,  o_dxy);
	lvrk_mul #(W, FRAC_BITS) u_lyy (clk, ly_s1,  y_s1, lyy_s2,  o_lyy);
	logic ov1_q;
	always_ff @(posedge clk) begin
		ax_s2 <= ax_s1;
		gy_s2 <= gy_s1;
		ov1_q <= ov_s1;
	end
	assign ov_s2 = ov1_q | o_bxy | o_kxx | o_dxy | o_lyy;

	// Stage 3: first subtractions.
	logic signed [W-1:0] rx_s3, ry_s3, kxx2_s3, lyy_s3;
	logic o_rx3, o_ry3, ov2_q;
	lvrk_add #(W) u_rx3 (clk, 1'b1, ax_s2,  bxy_s2, rx_s3, o_rx3);
	lvrk_add #(W) u_ry3 (clk, 1'b1, dxy_s2, gy_s2,  ry_s3, o_ry3);
	always_ff @(posedge clk) begin
		kxx2_s3 <= kxx2_s2;
		lyy_s3  <= lyy_s2;
		ov2_q   <= ov_s2;
	end

	// Stage 4: crowding terms.
	logic signed [W-1:0] fx_s4, fy_s4;
	logic o_fx, o_fy, ov3_q;
	lvrk_add #(W) u_fx (clk, 1'b1, rx_s3, kxx2_s3, fx_s4, o_fx);
	lvrk_add #(W) u_fy (clk, 1'b1, ry_s3, lyy_s3,  fy_s4, o_fy);
	always_ff @(posedge clk) ov3_q <= ov2_q | o_rx3 | o_ry3;

	// Stage 5: scale by the step size.
	logic o_kx5, o_ky5, ov4_q;
	lvrk_mul #(W, FRAC_BITS) u_kx5 (clk, dt, fx_s4, kx, o_kx5);
	lvrk_mul #(W, FRAC_BITS) u_ky5 (clk, dt, fy_s4, ky, o_ky5);
	always_ff @(posedge clk) ov4_q <= ov3_q | o_fx | o_fy;
	assign ov = ov4_q | o_kx5 | o_ky5;
endmodule

/* hdl/lotka_volterra_rk4_step.sv */
// Top level of the pipelined Lotka-Volterra RK4 step with its register file.
// One item is accepted per clock whenever start is high; busy is never raised, as nothing
// in the pipeline stalls. The pipeline is made of four RK4 stages, the three probe-point
// adds between them, and a tail that doubles k2 and k3, does three sum adds, the scale by
// one sixth and the final add. Results cannot be held off.
// Configuration must be written only while no item is in flight.
module lotka_volterra_rk4_step #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [WORD_WIDTH-1:0]           prey_in,
	input  logic signed [WORD_WIDTH-1:0]           predator_in,
	output logic                                   done,
	output logic signed [WORD_WIDTH-1:0]           prey_out,
	output logic signed [WORD_WIDTH-1:0]           predator_out,
	output logic                                   overflow,
	input  logic                                   cfg_we,
	input  logic [lvrk_pkg::IDX_W-1:0]             cfg_index,
	input  logic [WORD_WIDTH-2:0]                  cfg_data
);
	import lvrk_pkg::*;

	localparam int W = WORD_WIDTH;
	localparam int STAGE_LAT = 5;
	localparam int LAT = 4 * STAGE_LAT + 3 + 6;
	localparam int DX_LAT = STAGE_LAT + 1;
	localparam longint WMAXL = (longint'(1) << (W - 1)) - 1;

	localparam longint ALPHA_RAW = ((longint'(4807) << FRAC_BITS) + 5000) / 10000;
	localparam longint BETA_RAW  = ((longint'(2482) << FRAC_BITS) + 50000) / 100000;
	localparam longint DELTA_RAW = ((longint'(2756) << FRAC_BITS) + 50000) / 100000;
	localparam longint GAMMA_RAW = ((longint'(9272) << FRAC_BITS) + 5000) / 10000;
	localparam longint DT_RAW    = ((longint'(1) << FRAC_BITS) + 50) / 100;
	localparam longint SIXTH_RAW = ((longint'(1) << FRAC_BITS) + 3) / 6;

	function automatic logic [W-2:0] clamp_const(input longint v);
		longint c;
		begin
			c = (v > WMAXL) ? WMAXL : v;
			return c[W-2:0];
		end
	endfunction

	localparam logic [W-2:0] ALPHA_RST = clamp_const(ALPHA_RAW);
	localparam logic [W-2:0] BETA_RST  = clamp_const(BETA_RAW);
	localparam logic [W-2:0] DELTA_RST = clamp_const(DELTA_RAW);
	localparam logic [W-2:0] GAMMA_RST = clamp_const(GAMMA_RAW);
	localparam logic [W-2:0] DT_RST    = clamp_const(DT_RAW);
	localparam logic [W-2:0] SIXTH     = clamp_const(SIXTH_RAW);

	logic [W-2:0] regs_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_ALPHA]  <= ALPHA_RST;
			regs_q[REG_BETA]   <= BETA_RST;
			regs_q[REG_DELTA]  <= DELTA_RST;
			regs_q[REG_GAMMA]  <= GAMMA_RST;
			regs_q[REG_KAPPA]  <= '0;
			regs_q[REG_LAMBDA] <= '0;
			regs_q[REG_DT]     <= DT_RST;
		end else if (cfg_we && (32'(cfg_index) < NUM_REGS)) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	logic signed [W-1:0] alpha, beta, delta, gamma, kappa, lambda, dt;
	assign alpha  = {1'b0, regs_q[REG_ALPHA]};
	assign beta   = {1'b0, regs_q[REG_BETA]};
	assign delta  = {1'b0, regs_q[REG_DELTA]};
	assign gamma  = {1'b0, regs_q[REG_GAMMA]};
	assign kappa  = {1'b0, regs_q[REG_KAPPA]};
	assign lambda = {1'b0, regs_q[REG_LAMBDA]};
	assign dt     = {1'b0, regs_q[REG_DT]};

	assign busy = 1'b0;

	// Valid bits and the original state travel along the pipeline.
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else         vld_q <= {vld_q[LAT-2:0], start};
	end
	assign done = vld_q[LAT-1];

	logic signed [W-1:0] xd_q [LAT-1];
	logic signed [W-1:0] yd_q [LAT-1];
	always_ff @(posedge clk) begin
		xd_q[0] <= prey_in;
		yd_q[0] <= predator_in;
		for (int i = 1; i < LAT-1; i++) begin
			xd_q[i] <= xd_q[i-1];
			yd_q[i] <= yd_q[i-1];
		end
	end

	// RK4 stage 1.
	logic signed [W-1:0] kx1, ky1, kx2, ky2, kx3, ky3, kx4, ky4;
	logic o1, o2, o3, o4;
	lvrk_stage #(W, FRAC_BITS) u_st1 (clk, alpha, beta, delta, gamma, kappa, lambda, dt,
		prey_in, predator_in, kx1, ky1, o1);

	// Probe point 2: x + k1/2.
	logic signed [W-1:0] xa2, ya2;
	logic oa2x, oa2y;
	lvrk_add #(W) u_a2x (clk, 1'b0, xd_q[STAGE_LAT-1], kx1 >>> 1, xa2, oa2x);
	lvrk_add #(W) u_a2y (clk, 1'b0, yd_q[STAGE_LAT-1], ky1 >>> 1, ya2, oa2y);
	lvrk_stage #(W, FRAC_BITS) u_st2 (clk, alpha, beta, delta, gamma, kappa, lambda, dt,
		xa2, ya2, kx2, ky2, o2);

	logic signed [W-1:0] xa3, ya3;
	logic oa3x, oa3y;
	lvrk_add #(W) u_a3x (clk, 1'b0, xd_q[DX_LAT+STAGE_LAT-1], kx2 >>> 1, xa3, oa3x);
	lvrk_add #(W) u_a3y (clk, 1'b0, yd_q[DX_LAT+STAGE_LAT-1], ky2 >>> 1, ya3, oa3y);
	lvrk_stage #(W, FRAC_BITS) u_st3 (clk, alpha, beta, delta, gamma, kappa, lambda, dt,
		xa3, ya3, kx3, ky3, o3);

	logic signed [W-1:0] xa4, ya4;
	logic oa4x, oa4y;
	lvrk_add #(W) u_a4x (clk, 1'b0, xd_q[2*DX_LAT+STAGE_LAT-1], kx3, xa4, oa4x);
	lvrk_add #(W) u_a4y (clk, 1'b0, yd_q[2*DX_LAT+STAGE_LAT-1], ky3, ya4, oa4y);
	lvrk_stage #(W, FRAC_BITS) u_st4 (clk, alpha, beta, delta, gamma, kappa, lambda, dt,
		xa4, ya4, kx4, ky4, o4);

	// Delay the k values to line up with k4 (k1 waits 3 stages, k2 two, k3 one).
	logic signed [W-1:0] kx1_d [3*DX_LAT];
	logic signed [W-1:0] ky1_d [3*DX_LAT];
	logic signed [W-1:0] kx2_d [2*DX_LAT];
	logic signed [W-1:0] ky2_d [2*DX_LAT];
	logic signed [W-1:0] kx3_d [DX_LAT];
	logic signed [W-1:0] ky3_d [DX_LAT];
	logic [3*DX_LAT-1:0] ov1_d;
	logic [2*DX_LAT-1:0] ov2_d;
	logic [DX_LAT-1:0]   ov3_d;
	// The probe-point add flags arrive in the cycle after the stage flag, so they join
	// each overflow chain at its second register.
	always_ff @(posedge clk) begin
		kx1_d[0] <= kx1;
		ky1_d[0] <= ky1;
		ov1_d[0] <= o1;
		ov1_d[1] <= ov1_d[0] | oa2x | oa2y;
		for (int i = 1; i < 3*DX_LAT; i++) begin
			kx1_d[i] <= kx1_d[i-1];
			ky1_d[i] <= ky1_d[i-1];
		end
		for (int i = 2; i < 3*DX_LAT; i++)
			ov1_d[i] <= ov1_d[i-1];
		kx2_d[0] <= kx2;
		ky2_d[0] <= ky2;
		ov2_d[0] <= o2;
		ov2_d[1] <= ov2_d[0] | oa3x | oa3y;
		for (int i = 1; i < 2*DX_LAT; i++) begin
			kx2_d[i] <= kx2_d[i-1];
			ky2_d[i] <= ky2_d[i-1];
		end
		for (int i = 2; i < 2*DX_LAT; i++)
			ov2_d[i] <= ov2_d[i-1];
		kx3_d[0] <= kx3;
		ky3_d[0] <= ky3;
		ov3_d[0] <= o3;
		ov3_d[1] <= ov3_d[0] | oa4x | oa4y;
		for (int i = 1; i < DX_LAT; i++) begin
			kx3_d[i] <= kx3_d[i-1];
			ky3_d[i] <= ky3_d[i-1];
		end
		for (int i = 2; i < DX_LAT; i++)
			ov3_d[i] <= ov3_d[i-1];
	end
	logic ovk;
	assign ovk = ov1_d[3*DX_LAT-1] | ov2_d[2*DX_LAT-1] | ov3_d[DX_LAT-1] | o4;

	// Weighted sum: k2 and k3 are doubled first, then the terms are added in turn by registered adders.
	logic signed [W-1:0] kx1w, ky1w, kx2w, ky2w, kx3w, ky3w;
	assign kx1w = kx1_d[3*DX_LAT-1];
	assign ky1w = ky1_d[3*DX_LAT-1];
	assign kx2w = kx2_d[2*DX_LAT-1];
	assign ky2w = ky2_d[2*DX_LAT-1];
	assign kx3w = kx3_d[DX_LAT-1];
	assign ky3w = ky3_d[DX_LAT-1];

	logic signed [W-1:0] dx2, dy2, dx3, dy3, k1x_s, k1y_s, k4x_s, k4y_s;
	logic od2x, od2y, od3x, od3y, ovk_s;
	lvrk_add #(W) u_d2x (clk, 1'b0, kx2w, kx2w, dx2, od2x);
	lvrk_add #(W) u_d2y (clk, 1'b0, ky2w, ky2w, dy2, od2y);
	lvrk_add #(W) u_d3x (clk, 1'b0, kx3w, kx3w, dx3, od3x);
	lvrk_add #(W) u_d3y (clk, 1'b0, ky3w, ky3w, dy3, od3y);
	always_ff @(posedge clk) begin
		k1x_s <= kx1w;
		k1y_s <= ky1w;
		k4x_s <= kx4;
		k4y_s <= ky4;
		ovk_s <= ovk;
	end

	logic signed [W-1:0] s1x, s1y, k3x_t, k3y_t, k4x_t, k4y_t;
	logic os1x, os1y, ovs_t;
	lvrk_add #(W) u_s1x (clk, 1'b0, k1x_s, dx2, s1x, os1x);
	lvrk_add #(W) u_s1y (clk, 1'b0, k1y_s, dy2, s1y, os1y);
	always_ff @(posedge clk) begin
		k3x_t <= dx3;
		k3y_t <= dy3;
		k4x_t <= k4x_s;
		k4y_t <= k4y_s;
		ovs_t <= ovk_s | od2x | od2y | od3x | od3y;
	end

	logic signed [W-1:0] s2x, s2y, k4x_u, k4y_u;
	logic os2x, os2y, ovs_u;
	lvrk_add #(W) u_s2x (clk, 1'b0, s1x, k3x_t, s2x, os2x);
	lvrk_add #(W) u_s2y (clk, 1'b0, s1y, k3y_t, s2y, os2y);
	always_ff @(posedge clk) begin
		k4x_u <= k4x_t;
		k4y_u <= k4y_t;
		ovs_u <= ovs_t | os1x | os1y;
	end

	logic signed [W-1:0] s3x, s3y;
	logic os3x, os3y, ovs_v;
	lvrk_add #(W) u_s3x (clk, 1'b0, s2x, k4x_u, s3x, os3x);
	lvrk_add #(W) u_s3y (clk, 1'b0, s2y, k4y_u, s3y, os3y);
	always_ff @(posedge clk) ovs_v <= ovs_u | os2x | os2y;

	logic signed [W-1:0] mx, my;
	logic omx, omy, ovs_w;
	lvrk_mul #(W, FRAC_BITS) u_mx (clk, {1'b0, SIXTH}, s3x, mx, omx);
	lvrk_mul #(W, FRAC_BITS) u_my (clk, {1'b0, SIXTH}, s3y, my, omy);
	always_ff @(posedge clk) ovs_w <= ovs_v | os3x | os3y;

	logic ofx, ofy, ovs_x;
	lvrk_add #(W) u_fx (clk, 1'b0, xd_q[LAT-2], mx, prey_out, ofx);
	lvrk_add #(W) u_fy (clk, 1'b0, yd_q[LAT-2], my, predator_out, ofy);
	always_ff @(posedge clk) ovs_x <= ovs_w | omx | omy;
	assign overflow = ovs_x | ofx | ofy;

	assert property (@(posedge clk) disable iff (!arst_n) busy == 1'b0)
		else $error("busy raised");
	assert property (@(posedge clk) disable iff (!arst_n) start |-> ##LAT done)
		else $error("result missing after latency");
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(vld_q[LAT-2]) == done)
		else $error("done out of step with pipeline");
endmodule

/* sim/lotka_volterra_rk4_step_tb.sv */
// Self-checking testbench for the pipelined Lotka-Volterra RK4 step.
module lotka_volterra_rk4_step_tb;
	import lvrk_pkg::*;

	localparam int W = 32;
	localparam int FB = 20;
	localparam int PIPE_DRAIN = 30;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam longint SIXTH = ((64'sd1 << FB) + 3) / 6;
	localparam logic [IDX_W-1:0] IDX_SPARE = 3'd7;
	localparam logic [W-2:0] CMAX = '1;

	typedef struct {
		logic signed [W-1:0] prey;
		logic signed [W-1:0] predator;
		logic                ovf;
	} lv_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic signed [W-1:0] prey_in = '0;
	logic signed [W-1:0] predator_in = '0;
	logic                done;
	logic signed [W-1:0] prey_out;
	logic signed [W-1:0] predator_out;
	logic                overflow;
	logic                cfg_we = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [W-2:0]        cfg_data = '0;

	longint     coef[NUM_REGS];
	lv_result_t pending_steps[$];
	int         mismatches = 0;

	lotka_volterra_rk4_step u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.prey_in(prey_in), .predator_in(predator_in),
		.done(done), .prey_out(prey_out), .predator_out(predator_out),
		.overflow(overflow),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint sat(input longint v, inout bit ovf);
		if (v > WMAX) begin
			ovf = 1'b1;
			return WMAX;
		end
		if (v < WMIN) begin
			ovf = 1'b1;
			return WMIN;
		end
		return v;
	endfunction

	// Operands never exceed 32 bits, so the full product fits in 64 bits.
	function automatic longint qmul(input longint a, input longint b, inout bit ovf);
		return sat((a * b) >>> FB, ovf);
	endfunction

	function automatic longint prey_slope(input longint x, input longint y, inout bit ovf);
		longint r;
		r = qmul(coef[REG_ALPHA], x, ovf);
		r = sat(r - qmul(qmul(coef[REG_BETA], x, ovf), y, ovf), ovf);
		return sat(r - qmul(qmul(coef[REG_KAPPA], x, ovf), x, ovf), ovf);
	endfunction

	function automatic longint predator_slope(input longint x, input longint y,
		inout bit ovf);
		longint r;
		r = qmul(qmul(coef[REG_DELTA], x, ovf), y, ovf);
		r = sat(r - qmul(coef[REG_GAMMA], y, ovf), ovf);
		return sat(r - qmul(qmul(coef[REG_LAMBDA], y, ovf), y, ovf), ovf);
	endfunction

	function automatic lv_result_t rk4_predict(input logic signed [W-1:0] x_in,
		input logic signed [W-1:0] y_in);
		lv_result_t res;
		bit     ovf;
		longint x, y, dt, xa, ya, sx, sy;
		longint kx[4], ky[4];
		ovf = 1'b0;
		x = x_in;
		y = y_in;
		dt = coef[REG_DT];
		xa = x;
		ya = y;
		for (int i = 0; i < 4; i++) begin
			kx[i] = qmul(dt, prey_slope(xa, ya, ovf), ovf);
			ky[i] = qmul(dt, predator_slope(xa, ya, ovf), ovf);
			// Midpoint probes use half the slope, the last probe uses it whole.
			if (i < 3) begin
				xa = sat(x + ((i < 2) ? (kx[i] >>> 1) : kx[i]), ovf);
				ya = sat(y + ((i < 2) ? (ky[i] >>> 1) : ky[i]), ovf);
			end
		end
		sx = sat(kx[0] + sat(kx[1] + kx[1], ovf), ovf);
		sx = sat(sx + sat(kx[2] + kx[2], ovf), ovf);
		sx = sat(sx + kx[3], ovf);
		sy = sat(ky[0] + sat(ky[1] + ky[1], ovf), ovf);
		sy = sat(sy + sat(ky[2] + ky[2], ovf), ovf);
		sy = sat(sy + ky[3], ovf);
		res.prey = sat(x + qmul(SIXTH, sx, ovf), ovf);
		res.predator = sat(y + qmul(SIXTH, sy, ovf), ovf);
		res.ovf = ovf;
		return res;
	endfunction

	always @(posedge clk) begin
		lv_result_t exp_r;
		if (arst_n && done) begin
			if (pending_steps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result prey=%0d predator=%0d",
						prey_out, predator_out);
			end else begin
				exp_r = pending_steps.pop_front();
				if (prey_out !== exp_r.prey || predator_out !== exp_r.predator ||
					overflow !== exp_r.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: exp %0d %0d ov=%0b, got %0d %0d ov=%0b",
							exp_r.prey, exp_r.predator, exp_r.ovf,
							prey_out, predator_out, overflow);
				end
			end
		end
	end

	task automatic send_item(input logic signed [W-1:0] x, input logic signed [W-1:0] y);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		prey_in = x;
		predator_in = y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_steps.push_back(rk4_predict(x, y));
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		start = 1'b0;
		while (pending_steps.size() != 0)
			@(negedge clk);
		repeat (PIPE_DRAIN) @(negedge clk);
	endtask

	task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [W-2:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx < NUM_REGS)
			coef[idx] = value;
	endtask

	function automatic logic signed [W-1:0] rand_population();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return -W'($urandom_range(0, 200 << FB));
			default: return $urandom_range(0, 200 << FB);
		endcase
	endfunction

	function automatic logic [W-2:0] rand_coef(input bit is_dt);
		case ($urandom_range(0, 5))
			0: return (W-1)'($urandom);
			1: return '0;
			default: return is_dt ? (W-1)'($urandom_range(0, 1 << 17))
			                      : (W-1)'($urandom_range(0, 2 << FB));
		endcase
	endfunction

	task automatic test_defaults();
		logic signed [W-1:0] edge_vals[6];
		edge_vals = '{0, 1, -1, 32'sh7fffffff, 32'sh80000000, 32'sd41943040};
		foreach (edge_vals[i])
			foreach (edge_vals[j])
				if (i < 4 || j < 4)
					send_item(edge_vals[i], edge_vals[j]);
		send_item(32'sd20971520, 32'sd10485760);
		drain_pipeline();
	endtask

	task automatic test_coef_extremes();
		// Crowding terms on, then every coefficient at its top value, then all zero.
		write_coef(REG_KAPPA, 31'd10486);
		write_coef(REG_LAMBDA, 31'd5243);
		write_coef(IDX_SPARE, CMAX);
		send_item(32'sd31457280, 32'sd5242880);
		send_item(-32'sd31457280, 32'sd5242880);
		drain_pipeline();
		for (int i = 0; i < NUM_REGS; i++)
			write_coef(i[IDX_W-1:0], CMAX);
		send_item(32'sd1048576, 32'sd1048576);
		send_item(32'sh7fffffff, 32'sh80000000);
		send_item(0, 0);
		drain_pipeline();
		for (int i = 0; i < NUM_REGS; i++)
			write_coef(i[IDX_W-1:0], '0);
		send_item(32'sh7fffffff, 32'sh7fffffff);
		send_item(32'sd1048576, -32'sd1048576);
		drain_pipeline();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 8; phase++) begin
			for (int i = 0; i < NUM_REGS; i++)
				write_coef(i[IDX_W-1:0], rand_coef(i == REG_DT));
			if (phase == 0)
				write_coef(IDX_SPARE, (W-1)'($urandom));
			for (int n = 0; n < 250; n++)
				send_item(rand_population(), rand_population());
			drain_pipeline();
		end
	endtask

	initial begin
		coef = '{504050, 26026, 28899, 972240, 0, 0, 10486};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_defaults();
		test_coef_extremes();
		test_random();
		if (mismatches == 0)
			$display("PASS lotka_volterra_rk4_step");
		else
			$display("FAIL lotka_volterra_rk4_step");
		$finish;
	end

	initial begin
		#50000000;
		$display("FAIL lotka_volterra_rk4_step");
		$finish;
	end

endmodule
